/* rtl/trp_pkg.sv */
// Shared types and constants for the turtle raster plotter.
// Holds the transaction payload structs, command codes, heading codes and the
// controller/datapath command and status structs. No dependencies.
package trp_pkg;

   // Raster geometry.
   localparam int GRID_SIZE = 32;
   localparam int ROW_BITS  = 32;
   localparam int ROW_COUNT = 32;

   // Command codes.
   localparam logic [2:0] OP_PEN_UP     = 3'd0;
   localparam logic [2:0] OP_PEN_DOWN   = 3'd1;
   localparam logic [2:0] OP_TURN_RIGHT = 3'd2;
   localparam logic [2:0] OP_TURN_LEFT  = 3'd3;
   localparam logic [2:0] OP_FORWARD    = 3'd4;
   localparam logic [2:0] OP_READ_ROW   = 3'd5;

   // Heading codes.
   localparam logic [1:0] HEAD_EAST  = 2'd0;
   localparam logic [1:0] HEAD_SOUTH = 2'd1;
   localparam logic [1:0] HEAD_WEST  = 2'd2;
   localparam logic [1:0] HEAD_NORTH = 2'd3;

   typedef struct packed {
      logic [2:0] operation;
      logic [4:0] distance;
      logic [4:0] row_index;
   } req_type;

   typedef struct packed {
      logic [4:0]  pos_row;
      logic [4:0]  pos_col;
      logic [1:0]  heading;
      logic        pen_is_down;
      logic        move_error;
      logic [31:0] row_bits;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load_req;     // capture the accepted command
      logic exec;         // carry out the captured command
      logic vstep;        // mark one row of a vertical move
      logic finish_move;  // commit the new position of a vertical move
      logic load_rsp;     // load the result register
   } trp_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic needs_steps;  // command is an in-range vertical pen-down move of nonzero length
      logic last_step;    // current vertical step is the final cell
   } trp_status_type;

endpackage

/* rtl/turtle_raster_plotter_unit.sv */
// A transaction is captured, executed and, once the result register is free, loaded
// as the result; a vertical forward move with the pen down adds one step per cell moved.
// A new command is taken only after the result of the last one is loaded; the
// vertical steps are set by the single raster row access done in the datapath.
// Reset (synchronous): raster cleared, turtle at (0,0) heading east, pen up.
// Depends on trp_pkg, trp_ctrl and trp_datapath.
module turtle_raster_plotter_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  trp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output trp_pkg::rsp_type rsp_data
);
   import trp_pkg::*;

   trp_cmd_type    cmd;
   trp_status_type status;

   // Sequencing.
   trp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Turtle state, raster and result register.
   trp_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

/* rtl/trp_ctrl.sv */
// Controller state machine for the turtle raster plotter.
// Sequences command capture, execution, vertical marking steps and result load.
// Depends on trp_pkg.
module trp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  trp_pkg::trp_status_type status,
   output trp_pkg::trp_cmd_type    cmd
);
   import trp_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_VSTEP  = 2'd2;
   localparam logic [1:0] ST_REPORT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       slot_free;

   // The result register can take a new transaction when empty or draining.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.needs_steps ? ST_VSTEP : ST_REPORT;
         end
         ST_VSTEP: begin
            cmd.vstep = 1'b1;
            if (status.last_step) begin
               cmd.finish_move = 1'b1;
               state_in        = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid is set on load and cleared once the transaction is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/trp_datapath.sv */
// Datapath for the turtle raster plotter: turtle state, raster rows,
// bounds check, marking masks and the result register.
// Depends on trp_pkg.
module trp_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  trp_pkg::req_type        req_data,
   input  trp_pkg::trp_cmd_type    cmd,
   output trp_pkg::trp_status_type status,
   output trp_pkg::rsp_type        rsp_data
);
   import trp_pkg::*;

   localparam logic [5:0]          GRID_LIMIT = 6'(GRID_SIZE);
   localparam logic [ROW_BITS-1:0] ALL_ONES   = '1;

   req_type               cmd_ff;
   logic [4:0]            row_ff, row_in;
   logic [4:0]            col_ff, col_in;
   logic [1:0]            head_ff, head_in;
   logic                  pen_ff, pen_in;
   logic                  err_ff, err_in;
   logic [ROW_BITS-1:0]   bits_ff, bits_in;
   logic [4:0]            step_ff, step_in;
   logic [ROW_BITS-1:0]   raster_ff [ROW_COUNT];
   rsp_type               rsp_ff;

   logic [4:0]            new_row, new_col;
   logic                  fwd_ok;
   logic                  vertical;
   logic [4:0]            mask_lo, mask_hi;
   logic [ROW_BITS-1:0]   hmask, cell_bit;
   logic [4:0]            acc_addr;
   logic [ROW_BITS-1:0]   acc_row;
   logic                  wr_en;
   logic [ROW_BITS-1:0]   wr_mask;

   // Bounds check and target position of a forward move.
   always_comb begin
      new_row = row_ff;
      new_col = col_ff;
      fwd_ok  = 1'b0;
      unique case (head_ff)
         HEAD_EAST: begin
            fwd_ok  = ({1'b0, col_ff} + {1'b0, cmd_ff.distance}) < GRID_LIMIT;
            new_col = col_ff + cmd_ff.distance;
         end
         HEAD_SOUTH: begin
            fwd_ok  = ({1'b0, row_ff} + {1'b0, cmd_ff.distance}) < GRID_LIMIT;
            new_row = row_ff + cmd_ff.distance;
         end
         HEAD_WEST: begin
            fwd_ok  = cmd_ff.distance <= col_ff;
            new_col = col_ff - cmd_ff.distance;
         end
         HEAD_NORTH: begin
            fwd_ok  = cmd_ff.distance <= row_ff;
            new_row = row_ff - cmd_ff.distance;
         end
         default: begin
            fwd_ok = 1'b0;
         end
      endcase
   end

   assign vertical = (head_ff == HEAD_SOUTH) || (head_ff == HEAD_NORTH);

   assign status.needs_steps = (cmd_ff.operation == OP_FORWARD) && fwd_ok && pen_ff
                               && vertical && (cmd_ff.distance != 5'd0);
   assign status.last_step   = (step_ff == cmd_ff.distance);

   // Cells passed by a horizontal move span one contiguous run in the row.
   always_comb begin
      if (head_ff == HEAD_WEST) begin
         mask_lo = col_ff - cmd_ff.distance;
         mask_hi = col_ff - 5'd1;
      end else begin
         mask_lo = col_ff + 5'd1;
         mask_hi = col_ff + cmd_ff.distance;
      end
      hmask    = (ALL_ONES >> (5'd31 - mask_hi)) & (ALL_ONES << mask_lo);
      cell_bit = ROW_BITS'(1) << col_ff;
   end

   // Single raster access: one row address, read and optionally OR-written.
   always_comb begin
      acc_addr = row_ff;
      wr_en    = 1'b0;
      wr_mask  = cell_bit;
      if (cmd.vstep) begin
         acc_addr = (head_ff == HEAD_SOUTH) ? (row_ff + step_ff) : (row_ff - step_ff);
         wr_en    = 1'b1;
      end else if (cmd.exec) begin
         unique case (cmd_ff.operation)
            OP_PEN_DOWN: begin
               wr_en = 1'b1;
            end
            OP_FORWARD: begin
               wr_en   = fwd_ok && pen_ff && !vertical && (cmd_ff.distance != 5'd0);
               wr_mask = hmask;
            end
            OP_READ_ROW: begin
               acc_addr = cmd_ff.row_index;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   assign acc_row = raster_ff[acc_addr];

   // Turtle state updates.
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      head_in = head_ff;
      pen_in  = pen_ff;
      err_in  = err_ff;
      bits_in = bits_ff;
      step_in = step_ff;
      if (cmd.exec) begin
         err_in  = 1'b0;
         bits_in = '0;
         step_in = 5'd1;
         unique case (cmd_ff.operation)
            OP_PEN_UP:     pen_in  = 1'b0;
            OP_PEN_DOWN:   pen_in  = 1'b1;
            OP_TURN_RIGHT: head_in = head_ff + 2'd1;
            OP_TURN_LEFT:  head_in = head_ff - 2'd1;
            OP_FORWARD: begin
               err_in = !fwd_ok;
               if (fwd_ok && !status.needs_steps) begin
                  row_in = new_row;
                  col_in = new_col;
               end
            end
            OP_READ_ROW: begin
               if ({1'b0, cmd_ff.row_index} < GRID_LIMIT) begin
                  bits_in = acc_row;
               end
            end
            default: begin
               err_in = 1'b0;
            end
         endcase
      end
      if (cmd.vstep) begin
         step_in = step_ff + 5'd1;
      end
      if (cmd.finish_move) begin
         row_in = new_row;
         col_in = new_col;
      end
   end

   // Turtle registers and command capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= 5'd0;
         col_ff  <= 5'd0;
         head_ff <= HEAD_EAST;
         pen_ff  <= 1'b0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         head_ff <= head_in;
         pen_ff  <= pen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff <= req_data;
      end
      err_ff  <= err_in;
      bits_ff <= bits_in;
      step_ff <= step_in;
   end

   // Raster rows, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROW_COUNT; i++) begin
            raster_ff[i] <= '0;
         end
      end else if (wr_en) begin
         raster_ff[acc_addr] <= acc_row | wr_mask;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.pos_row     <= row_ff;
         rsp_ff.pos_col     <= col_ff;
         rsp_ff.heading     <= head_ff;
         rsp_ff.pen_is_down <= pen_ff;
         rsp_ff.move_error  <= err_ff;
         rsp_ff.row_bits    <= bits_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* rtl/trp_checker.sv */
// Port-level checker for the turtle raster plotter, bound to the top level.
// Depends on trp_pkg and turtle_raster_plotter_unit.
module trp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input trp_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input trp_pkg::rsp_type rsp_data
);
   import trp_pkg::*;

   // A stalled result transaction stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result transaction changed while stalled");

   // The block works on one command at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while a command is in progress");

   // A refused move never reports raster contents.
   a_err_no_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.move_error |-> rsp_data.row_bits == 32'd0)
      else $error("move error reported with row bits");

   // Reset leaves the block idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind turtle_raster_plotter_unit trp_checker u_trp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/tb_turtle_raster_plotter_unit.sv */
// Self-checking testbench for turtle_raster_plotter_unit: directed and random
// command streams, a built-in turtle predictor, and random idling on both sides.
// Depends on trp_pkg and the turtle_raster_plotter_unit RTL.
module tb_turtle_raster_plotter_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import trp_pkg::*;

   // The two command codes that the block must treat as no-ops.
   localparam logic [2:0] OP_RESERVED_A = 3'd6;
   localparam logic [2:0] OP_RESERVED_B = 3'd7;

   localparam int RANDOM_COMMANDS = 400;
   localparam int QUIET_TAIL      = 40;     // final commands sent without idling
   localparam int LONG_HOLD       = 300;    // receiver back-pressure stretch
   localparam int DRAIN_CYCLES    = 40;
   localparam int WATCHDOG_LIMIT  = 2000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   turtle_raster_plotter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Commands waiting to be sent and results the turtle should report.
   req_type pending_cmds[$];
   rsp_type expected_reports[$];

   // Shadow copy of the raster and the turtle.
   logic [31:0] shadow_raster [ROW_COUNT];
   int          turtle_row  = 0;
   int          turtle_col  = 0;
   logic [1:0]  turtle_head = HEAD_EAST;
   logic        turtle_pen  = 1'b0;

   int  mismatches   = 0;
   int  reports_seen = 0;
   bit  cmd_taken    = 1'b0;
   int  cmd_gap      = 0;
   int  report_gap   = 0;
   int  hold_left    = 0;
   bit  hold_done    = 1'b0;
   int  idle_cycles  = 0;

   initial begin
      for (int r = 0; r < ROW_COUNT; r++) shadow_raster[r] = '0;
   end

   initial begin
      forever #1 clock = ~clock;
   end

   // Apply one command to the shadow turtle and return the report it should give.
   function automatic rsp_type plot_command(input req_type cmd);
      rsp_type rep;
      int      d;
      int      new_row;
      int      new_col;
      bit      fits;
      rep     = '0;
      d       = int'(cmd.distance);
      new_row = turtle_row;
      new_col = turtle_col;
      fits    = 1'b1;
      case (cmd.operation)
         OP_PEN_UP: begin
            turtle_pen = 1'b0;
         end
         OP_PEN_DOWN: begin
            turtle_pen = 1'b1;
            shadow_raster[turtle_row][turtle_col] = 1'b1;
         end
         OP_TURN_RIGHT: begin
            turtle_head = turtle_head + 2'd1;
         end
         OP_TURN_LEFT: begin
            turtle_head = turtle_head - 2'd1;
         end
         OP_FORWARD: begin
            case (turtle_head)
               HEAD_EAST: begin
                  fits    = (turtle_col + d) < GRID_SIZE;
                  new_col = turtle_col + d;
               end
               HEAD_SOUTH: begin
                  fits    = (turtle_row + d) < GRID_SIZE;
                  new_row = turtle_row + d;
               end
               HEAD_WEST: begin
                  fits    = d <= turtle_col;
                  new_col = turtle_col - d;
               end
               default: begin
                  fits    = d <= turtle_row;
                  new_row = turtle_row - d;
               end
            endcase
            if (fits) begin
               // Every cell entered on the way gets marked while the pen is down.
               if (turtle_pen) begin
                  for (int i = 1; i <= d; i++) begin
                     case (turtle_head)
                        HEAD_EAST:  shadow_raster[turtle_row][turtle_col + i] = 1'b1;
                        HEAD_SOUTH: shadow_raster[turtle_row + i][turtle_col] = 1'b1;
                        HEAD_WEST:  shadow_raster[turtle_row][turtle_col - i] = 1'b1;
                        default:    shadow_raster[turtle_row - i][turtle_col] = 1'b1;
                     endcase
                  end
               end
               turtle_row = new_row;
               turtle_col = new_col;
            end else begin
               rep.move_error = 1'b1;
            end
         end
         OP_READ_ROW: begin
            if (cmd.row_index < GRID_SIZE) rep.row_bits = shadow_raster[cmd.row_index];
         end
         default: begin
         end
      endcase
      rep.pos_row     = turtle_row[4:0];
      rep.pos_col     = turtle_col[4:0];
      rep.heading     = turtle_head;
      rep.pen_is_down = turtle_pen;
      return rep;
   endfunction

   function automatic void queue_cmd(input logic [2:0] op, input int cells, input int row);
      req_type cmd;
      cmd.operation = op;
      cmd.distance  = cells[4:0];
      cmd.row_index = row[4:0];
      pending_cmds.push_back(cmd);
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatches++;
      end
   endtask

   // Record each accepted command and predict its report.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_reports.push_back(plot_command(req_data));
         cmd_taken = 1'b1;
      end else begin
         cmd_taken = 1'b0;
      end
   end

   // Compare each accepted report with the oldest prediction.
   always @(posedge clock) begin : report_monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         reports_seen++;
         if (expected_reports.size() == 0) begin
            $error("unexpected report transaction: 0x%0h", rsp_data);
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            check_field("pos_row",     32'(want.pos_row),     32'(rsp_data.pos_row));
            check_field("pos_col",     32'(want.pos_col),     32'(rsp_data.pos_col));
            check_field("heading",     32'(want.heading),     32'(rsp_data.heading));
            check_field("pen_is_down", 32'(want.pen_is_down), 32'(rsp_data.pen_is_down));
            check_field("move_error",  32'(want.move_error),  32'(rsp_data.move_error));
            check_field("row_bits",    want.row_bits,         rsp_data.row_bits);
         end
      end
   end

   // Command driver: holds a stalled transaction, otherwise sends or idles.
   always @(negedge clock) begin : command_driver
      logic    vld;
      req_type nxt;
      vld = req_valid;
      nxt = req_data;
      if (reset) begin
         vld = 1'b0;
      end else begin
         if (cmd_taken) begin
            pending_cmds.delete(0);
            vld = 1'b0;
         end
         if (!vld) begin
            if (cmd_gap > 0) begin
               cmd_gap--;
            end else if (pending_cmds.size() > 0) begin
               if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 15) == 0) begin
                  cmd_gap = $urandom_range(1, 17) - 1;
               end else begin
                  vld = 1'b1;
                  nxt = pending_cmds[0];
               end
            end
         end
      end
      req_valid <= vld;
      req_data  <= nxt;
   end

   // Report receiver: one long hold early in the random part, then random bursts.
   always @(negedge clock) begin : report_receiver
      logic stl;
      stl = 1'b0;
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            stl = 1'b1;
         end else if (!hold_done && reports_seen >= 30) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            stl       = 1'b1;
         end else if (report_gap > 0) begin
            report_gap--;
            stl = 1'b1;
         end else if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 15) == 0) begin
            report_gap = $urandom_range(1, 17) - 1;
            stl        = 1'b1;
         end
      end
      rsp_stall <= stl;
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("FAILURE");
         $finish;
      end
   end

   // Stimulus and end of test.
   initial begin : stimulus
      int         pick;
      logic [2:0] op;
      int         move_len;

      // Directed: fresh raster, three sides of the border traced, turns that
      // wrap, refused moves at each edge, zero distance, unused codes and
      // out-of-range reads never apply here since every row index is in range.
      queue_cmd(OP_READ_ROW,   0, 0);
      queue_cmd(OP_READ_ROW,   0, 31);
      queue_cmd(OP_TURN_LEFT,  0, 0);
      queue_cmd(OP_FORWARD,    1, 0);      // north off the top edge
      queue_cmd(OP_TURN_RIGHT, 0, 0);
      queue_cmd(OP_PEN_DOWN,   0, 0);
      queue_cmd(OP_FORWARD,    31, 0);     // east along row 0
      queue_cmd(OP_FORWARD,    1, 0);      // east off the right edge
      queue_cmd(OP_READ_ROW,   0, 0);
      queue_cmd(OP_TURN_RIGHT, 0, 0);
      queue_cmd(OP_FORWARD,    31, 0);     // south along the last column
      queue_cmd(OP_FORWARD,    0, 0);
      queue_cmd(OP_FORWARD,    1, 0);      // south off the bottom edge
      queue_cmd(OP_TURN_RIGHT, 0, 0);
      queue_cmd(OP_FORWARD,    31, 0);     // west along the last row
      queue_cmd(OP_FORWARD,    1, 0);      // west off the left edge
      queue_cmd(OP_TURN_RIGHT, 0, 0);
      queue_cmd(OP_PEN_UP,     0, 0);
      queue_cmd(OP_FORWARD,    15, 0);     // north with the pen up
      queue_cmd(OP_RESERVED_A, 31, 31);
      queue_cmd(OP_RESERVED_B, 21, 10);
      queue_cmd(OP_READ_ROW,   0, 31);
      queue_cmd(OP_READ_ROW,   0, 15);
      for (int i = 0; i < 4; i++) queue_cmd(OP_TURN_LEFT, 0, 0);

      // Random: forward moves most often, mostly short, so the turtle roams and draws.
      for (int n = 0; n < RANDOM_COMMANDS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35)      op = OP_FORWARD;
         else if (pick < 45) op = OP_PEN_DOWN;
         else if (pick < 52) op = OP_PEN_UP;
         else if (pick < 62) op = OP_TURN_RIGHT;
         else if (pick < 72) op = OP_TURN_LEFT;
         else if (pick < 95) op = OP_READ_ROW;
         else                op = $urandom_range(0, 1) ? OP_RESERVED_A : OP_RESERVED_B;
         move_len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7)
                                               : $urandom_range(0, 31);
         queue_cmd(op, move_len, $urandom_range(0, 31));
      end

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_valid) @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/trp_pkg.sv
rtl/trp_ctrl.sv
rtl/trp_datapath.sv
rtl/turtle_raster_plotter_unit.sv
rtl/trp_checker.sv
tb/tb_turtle_raster_plotter_unit.sv
